>>> hw/rtl/i2cbe_pkg.sv
// ---------------------------------------------------------------------------
// i2cbe_pkg
// Shared types and constants for the I2C master bit engine.
// ---------------------------------------------------------------------------
package i2cbe_pkg;

   localparam int DATA_W = 8;
   localparam int MODE_W = 3;
   localparam int CSR_INDEX_W = 1;

   localparam logic [MODE_W-1:0] MODE_START = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ACK   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_SETUP  = 1'b1;

   localparam logic [DATA_W-1:0] ACK_TIMEOUT_RST = 8'd250;
   localparam logic [DATA_W-1:0] EDGE_SETUP_RST  = 8'd15;
   localparam logic [DATA_W-1:0] MSB_MASK        = 8'h80;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_ACK,
      CMD_READ
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [DATA_W-1:0] tx_byte;
      logic              give_ack;
      logic              sda_sample;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] ack_timeout_ticks;
      logic [DATA_W-1:0] edge_setup_ticks;
   } cfg_type;

endpackage

>>> hw/rtl/i2cbe_ifs.sv
// ---------------------------------------------------------------------------
// i2cbe_ifs
// Valid/ready channel interfaces for tick requests and tick responses.
// ---------------------------------------------------------------------------
interface i2cbe_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] tx_byte;
   logic       give_ack;
   logic       sda_sample;

   modport source (output valid, output mode, output tx_byte, output give_ack,
                   output sda_sample, input ready);
   modport sink   (input valid, input mode, input tx_byte, input give_ack,
                   input sda_sample, output ready);
endinterface

interface i2cbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_enable;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_missing;

   modport source (output valid, output scl_level, output sda_level, output sda_enable,
                   output busy_res, output done_res, output rx_byte,
                   output ack_missing, input ready);
   modport sink   (input valid, input scl_level, input sda_level, input sda_enable,
                   input busy_res, input done_res, input rx_byte,
                   input ack_missing, output ready);
endinterface

>>> hw/rtl/i2cbe_front.sv
// ---------------------------------------------------------------------------
// i2cbe_front
// Accepts tick transactions, decodes the mode into a command and queues them
// in a two-entry FIFO for the bit engine.
// ---------------------------------------------------------------------------
module i2cbe_front (
   input  logic                    clock,
   input  logic                    reset,
   i2cbe_req_if.sink               req_chan,
   output logic                    item_valid,
   output i2cbe_pkg::req_item_type item,
   input  logic                    item_pop
);
   import i2cbe_pkg::*;

   req_item_type slot_ff [2];
   req_item_type slot_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   cmd_type      cmd_dec;
   logic         push;

   always_comb begin
      unique case (req_chan.mode)
         MODE_START: cmd_dec = CMD_START;
         MODE_STOP:  cmd_dec = CMD_STOP;
         MODE_WRITE: cmd_dec = CMD_WRITE;
         MODE_ACK:   cmd_dec = CMD_ACK;
         MODE_READ:  cmd_dec = CMD_READ;
         default:    cmd_dec = CMD_NONE;
      endcase
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (count_ff != 2'd0);
   assign item           = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in.cmd        = cmd_dec;
      slot_in.tx_byte    = req_chan.tx_byte;
      slot_in.give_ack   = req_chan.give_ack;
      slot_in.sda_sample = req_chan.sda_sample;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !item_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/i2cbe_engine.sv
// ---------------------------------------------------------------------------
// i2cbe_engine
// Bit sequencer: advances the SCL/SDA sequence by one tick per queued
// transaction and holds the pin levels and flags as the response register.
// ---------------------------------------------------------------------------
module i2cbe_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  i2cbe_pkg::cfg_type      cfg,
   input  logic                    item_valid,
   input  i2cbe_pkg::req_item_type item,
   output logic                    item_pop,
   i2cbe_rsp_if.source             rsp_chan
);
   import i2cbe_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_SETUP,
      ST_START_HOLD,
      ST_STOP_CLK,
      ST_STOP_LOW,
      ST_STOP_SETUP,
      ST_WR_FALL,
      ST_WR_NEXT,
      ST_ACK_POLL,
      ST_RD_SETUP,
      ST_RD_LOW,
      ST_RD_HIGH,
      ST_RA_DATA,
      ST_RA_RISE,
      ST_RA_FALL
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        bit_index_ff, bit_index_in;
   logic [DATA_W-1:0] shift_ff, shift_in;
   logic [DATA_W-1:0] tick_count_ff, tick_count_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic              sda_oe_ff, sda_oe_in;
   logic              ack_choice_ff, ack_choice_in;
   logic [DATA_W-1:0] rx_ff, rx_in;
   logic              ack_err_ff, ack_err_in;
   logic              done_ff, done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              wait_more;
   logic [3:0]        bit_next;

   assign item_pop  = item_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign wait_more = (tick_count_ff > 8'd1);
   assign bit_next  = bit_index_ff + 4'd1;

   always_comb begin
      state_in      = state_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      tick_count_in = tick_count_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      sda_oe_in     = sda_oe_ff;
      ack_choice_in = ack_choice_ff;
      rx_in         = rx_ff;
      ack_err_in    = ack_err_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (item_pop) begin
         rsp_valid_in = 1'b1;
         done_in      = 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               unique case (item.cmd)
                  CMD_START: begin
                     sda_oe_in     = 1'b1;
                     sda_in        = 1'b1;
                     scl_in        = 1'b1;
                     tick_count_in = cfg.edge_setup_ticks;
                     state_in      = ST_START_SETUP;
                  end
                  CMD_STOP: begin
                     scl_in   = 1'b0;
                     state_in = ST_STOP_CLK;
                  end
                  CMD_WRITE: begin
                     sda_oe_in    = 1'b1;
                     scl_in       = 1'b0;
                     shift_in     = item.tx_byte;
                     bit_index_in = 4'd0;
                     state_in     = ST_WR_NEXT;
                  end
                  CMD_ACK: begin
                     sda_oe_in     = 1'b0;
                     sda_in        = 1'b1;
                     scl_in        = 1'b1;
                     tick_count_in = '0;
                     ack_err_in    = 1'b0;
                     state_in      = ST_ACK_POLL;
                  end
                  CMD_READ: begin
                     sda_oe_in     = 1'b0;
                     shift_in      = '0;
                     bit_index_in  = 4'd0;
                     ack_choice_in = item.give_ack;
                     tick_count_in = cfg.edge_setup_ticks;
                     state_in      = ST_RD_SETUP;
                  end
                  default: ;
               endcase
            end
            ST_START_SETUP: begin
               if (wait_more) begin
                  tick_count_in = tick_count_ff - 8'd1;
               end else begin
                  sda_in   = 1'b0;
                  state_in = ST_START_HOLD;
               end
            end
            ST_START_HOLD: begin
               scl_in   = 1'b0;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
            ST_STOP_CLK: begin
               sda_oe_in = 1'b1;
               sda_in    = 1'b0;
               state_in  = ST_STOP_LOW;
            end
            ST_STOP_LOW: begin
               scl_in        = 1'b1;
               tick_count_in = cfg.edge_setup_ticks;
               state_in      = ST_STOP_SETUP;
            end
            ST_STOP_SETUP: begin
               if (wait_more) begin
                  tick_count_in = tick_count_ff - 8'd1;
               end else begin
                  sda_in   = 1'b1;
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
            ST_WR_FALL: begin
               scl_in       = 1'b0;
               bit_index_in = bit_next;
               state_in     = ST_WR_NEXT;
            end
            ST_WR_NEXT: begin
               if (bit_index_ff >= 4'd8) begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  sda_in   = |(shift_ff & MSB_MASK);
                  shift_in = {shift_ff[DATA_W-2:0], 1'b0};
                  scl_in   = 1'b1;
                  state_in = ST_WR_FALL;
               end
            end
            ST_ACK_POLL: begin
               if (!item.sda_sample) begin
                  scl_in   = 1'b0;
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else if (tick_count_ff >= cfg.ack_timeout_ticks) begin
                  ack_err_in = 1'b1;
                  scl_in     = 1'b0;
                  state_in   = ST_STOP_CLK;
               end else begin
                  tick_count_in = tick_count_ff + 8'd1;
               end
            end
            ST_RD_SETUP: begin
               if (wait_more) begin
                  tick_count_in = tick_count_ff - 8'd1;
               end else begin
                  scl_in   = 1'b0;
                  state_in = ST_RD_HIGH;
               end
            end
            ST_RD_LOW: begin
               scl_in   = 1'b0;
               state_in = ST_RD_HIGH;
            end
            ST_RD_HIGH: begin
               scl_in       = 1'b1;
               shift_in     = {shift_ff[DATA_W-2:0], item.sda_sample};
               bit_index_in = bit_next;
               state_in     = (bit_next >= 4'd8) ? ST_RA_DATA : ST_RD_LOW;
            end
            ST_RA_DATA: begin
               scl_in    = 1'b0;
               sda_oe_in = 1'b1;
               state_in  = ST_RA_RISE;
            end
            ST_RA_RISE: begin
               sda_in   = !ack_choice_ff;
               state_in = ST_RA_FALL;
            end
            ST_RA_FALL: begin
               if (!scl_ff) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in   = 1'b0;
                  rx_in    = shift_ff;
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bit_index_ff  <= 4'd0;
         shift_ff      <= '0;
         tick_count_ff <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         sda_oe_ff     <= 1'b1;
         ack_choice_ff <= 1'b0;
         rx_ff         <= '0;
         ack_err_ff    <= 1'b0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         tick_count_ff <= tick_count_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         sda_oe_ff     <= sda_oe_in;
         ack_choice_ff <= ack_choice_in;
         rx_ff         <= rx_in;
         ack_err_ff    <= ack_err_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.scl_level   = scl_ff;
   assign rsp_chan.sda_level   = sda_ff;
   assign rsp_chan.sda_enable  = sda_oe_ff;
   assign rsp_chan.busy_res    = (state_ff != ST_IDLE);
   assign rsp_chan.done_res    = done_ff;
   assign rsp_chan.rx_byte     = rx_ff;
   assign rsp_chan.ack_missing = ack_err_ff;

endmodule

>>> hw/rtl/i2c_master_bit_engine_core.sv
// I2C master bit engine. Every request transaction is one bit-timing tick that
// carries the sampled SDA level and, when the engine is idle, an optional
// command (start, stop, write byte, wait for ack, read byte with ack/nack).
// Every request yields exactly one response transaction with the SCL/SDA drive
// levels, busy, done, the last received byte and the ack-missing flag. The
// core takes one request per clock while its queue has room; a two-entry
// queue sits in front of the sequencer and a single response register sits
// behind it, so throughput is one tick per cycle whenever the response side
// is ready. With no back-pressure a request passes through the queue and
// then the response register. A held response stops the queue; once both
// queue entries and the response register are full, the request side stalls.
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_core
// Top level: CSR registers, request front end and bit sequencer.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   i2cbe_req_if.sink                           req_chan,
   i2cbe_rsp_if.source                         rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [i2cbe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [i2cbe_pkg::DATA_W-1:0]        csr_wdata
);
   import i2cbe_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         item_valid;
   req_item_type item;
   logic         item_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACK_TIMEOUT: cfg_in.ack_timeout_ticks = csr_wdata;
            CSR_EDGE_SETUP:  cfg_in.edge_setup_ticks  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_timeout_ticks <= ACK_TIMEOUT_RST;
         cfg_ff.edge_setup_ticks  <= EDGE_SETUP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2cbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   i2cbe_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTH
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> !rsp_chan.busy_res)
      else $error("done response while still busy");

   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (item_valid && (!rsp_chan.valid || rsp_chan.ready)))
      else $error("queue popped without a free response slot");

   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> item_valid)
      else $error("accepted transaction missing from queue");
`endif

endmodule
